// ===== sv/swept_box_collision_assert.svh =====
// Assertion macros shared by the swept box collision RTL.
// Depends on nothing; files that assert include it by name.
`ifndef SWEPT_BOX_COLLISION_ASSERT_SVH
`define SWEPT_BOX_COLLISION_ASSERT_SVH
`ifndef SYNTH
`define SWB_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define SWB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`define SWB_ASSERT_RESET(lbl, ck, rn, cons, msg) \
  lbl: assert property (@(posedge ck) (!rn) |=> (cons)) else $error(msg);
`else
`define SWB_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define SWB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`define SWB_ASSERT_RESET(lbl, ck, rn, cons, msg)
`endif
`endif

// ===== sv/swb_pkg.sv =====
// Package for the swept box collision block: time constants, face codes,
// sideband types and the quotient saturation function. No dependencies.
package swb_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int QW = 18;              // quotient bits, the top one flags overflow
  localparam int TIME_SHIFT = 11;      // doubled distances times 2048 give Q4.12
  localparam logic signed [15:0] T_ONE = 16'sd4096;
  localparam logic signed [15:0] T_MAX = 16'sd32767;
  localparam logic signed [15:0] T_MIN = -16'sd32768;

  typedef enum logic [1:0] {
    FACE_0    = 2'd0,
    FACE_PI2  = 2'd1,
    FACE_PI   = 2'd2,
    FACE_3PI2 = 2'd3
  } face_t;

  typedef struct packed {
    logic vzero;
    logic vneg;
    logic still_ok;
  } axis_sb_t;

  typedef struct packed {
    axis_sb_t x;
    axis_sb_t y;
    logic     ax_lt;
    logic     ay_lt;
  } pair_sb_t;

  // Turns an unsigned quotient magnitude into the floored, saturated Q4.12 time.
  function automatic logic signed [15:0] quo_sat(logic [QW-1:0] q, logic nz, logic neg);
    logic [QW-1:0] c;
    logic signed [15:0] res;
    c = {1'b0, q[QW-2:0]} + {{(QW-1){1'b0}}, nz};
    if (!neg) begin
      if (q[QW-1] || (q[QW-2:0] > 17'd32767)) res = T_MAX;
      else res = q[15:0];
    end else begin
      if (q[QW-1] || (c > 18'd32768)) res = T_MIN;
      else res = 16'(-c);
    end
    return res;
  endfunction

endpackage

// ===== sv/swept_box_collision.sv =====
// Top level of the swept box collision block: operand stage, four pipelined
// dividers, saturation stage, output register. Uses swb_pkg, swb_div, assert header.
//
//  channel | direction | word contents
//  in_     | slave     | two boxes: centers, sizes, velocities
//  out_    | master    | hit, hit_time, face_dir
//
// One word enters per cycle while out_ does not stall; each word passes the
// operand stage, the one-bit-per-stage division pipeline, saturation and output.
// Reset clears the valid bits and holds in_tready low. A stall on out_ freezes
// every stage at once, so nothing is lost or repeated; in_tready follows that stall.
module swept_box_collision import swb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_center_x, a_center_y, a_width, a_height, a_vel_x, a_vel_y,
  // b_center_x, b_center_y, b_width, b_height, b_vel_x, b_vel_y, zero pad
  input  logic [8*((12*COORD_BITS-4+7)/8)-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit, hit_time[15:0], face_dir[1:0], zero pad
  output logic [23:0] out_tdata
);
  `include "swept_box_collision_assert.svh"

  localparam int CB = COORD_BITS;
  localparam int SB = COORD_BITS - 1;
  localparam int NW = CB + 14;
  localparam int DW = CB + 1;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;

  logic signed [CB-1:0] a_cx, a_cy, a_vx, a_vy, b_cx, b_cy, b_vx, b_vy;
  logic        [SB-1:0] a_w, a_h, b_w, b_h;
  assign a_cx = in_tdata[CB-1:0];
  assign a_cy = in_tdata[2*CB-1:CB];
  assign a_w  = in_tdata[3*CB-2:2*CB];
  assign a_h  = in_tdata[4*CB-3:3*CB-1];
  assign a_vx = in_tdata[5*CB-3:4*CB-2];
  assign a_vy = in_tdata[6*CB-3:5*CB-2];
  assign b_cx = in_tdata[7*CB-3:6*CB-2];
  assign b_cy = in_tdata[8*CB-3:7*CB-2];
  assign b_w  = in_tdata[9*CB-4:8*CB-2];
  assign b_h  = in_tdata[10*CB-5:9*CB-3];
  assign b_vx = in_tdata[11*CB-5:10*CB-4];
  assign b_vy = in_tdata[12*CB-5:11*CB-4];

  // Per axis operand forming; distances are at doubled scale.
  typedef struct packed {
    logic [NW-1:0] lo_mag;
    logic          lo_neg;
    logic [NW-1:0] hi_mag;
    logic          hi_neg;
    logic [DW-1:0] v_mag;
    axis_sb_t      sb;
  } axis_op_t;

  function automatic axis_op_t axis_prep(logic signed [CB-1:0] ac, logic signed [CB-1:0] bc,
                                         logic [SB-1:0] asz, logic [SB-1:0] bsz,
                                         logic signed [CB-1:0] av, logic signed [CB-1:0] bv);
    axis_op_t o;
    logic signed [CB+2:0] d, s, lo, hi;
    logic signed [NW-1:0] nlo, nhi;
    logic signed [CB:0]   v;
    d  = ({{3{bc[CB-1]}}, bc} - {{3{ac[CB-1]}}, ac}) <<< 1;
    s  = {3'b000, {1'b0, asz} + {1'b0, bsz}};
    lo = d - s;
    hi = d + s;
    nlo = {{11{lo[CB+2]}}, lo} <<< TIME_SHIFT;
    nhi = {{11{hi[CB+2]}}, hi} <<< TIME_SHIFT;
    v   = {av[CB-1], av} - {bv[CB-1], bv};
    o.v_mag = v[CB] ? DW'(-v) : DW'(v);
    o.sb.vzero    = (v == '0);
    o.sb.vneg     = v[CB];
    o.sb.still_ok = (d > -s) && (d < s);
    o.lo_mag = nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
    o.hi_mag = nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
    o.lo_neg = nlo[NW-1] ^ v[CB];
    o.hi_neg = nhi[NW-1] ^ v[CB];
    return o;
  endfunction

  axis_op_t opx_r, opy_r;
  logic     ax_lt_r, ay_lt_r, a_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      opx_r   <= axis_prep(a_cx, b_cx, a_w, b_w, a_vx, b_vx);
      opy_r   <= axis_prep(a_cy, b_cy, a_h, b_h, a_vy, b_vy);
      ax_lt_r <= (a_cx < b_cx);
      ay_lt_r <= (a_cy < b_cy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_tvalid;
  end

  logic [QW-1:0] q_xlo, q_xhi, q_ylo, q_yhi;
  logic          nz_xlo, nz_xhi, nz_ylo, nz_yhi;
  logic          ng_xlo, ng_xhi, ng_ylo, ng_yhi;

  swb_div #(.NW(NW), .DW(DW)) u_div_xlo (.clk, .en, .num(opx_r.lo_mag), .den(opx_r.v_mag),
    .tag_in(opx_r.lo_neg), .quo(q_xlo), .rem_nz(nz_xlo), .tag_out(ng_xlo));
  swb_div #(.NW(NW), .DW(DW)) u_div_xhi (.clk, .en, .num(opx_r.hi_mag), .den(opx_r.v_mag),
    .tag_in(opx_r.hi_neg), .quo(q_xhi), .rem_nz(nz_xhi), .tag_out(ng_xhi));
  swb_div #(.NW(NW), .DW(DW)) u_div_ylo (.clk, .en, .num(opy_r.lo_mag), .den(opy_r.v_mag),
    .tag_in(opy_r.lo_neg), .quo(q_ylo), .rem_nz(nz_ylo), .tag_out(ng_ylo));
  swb_div #(.NW(NW), .DW(DW)) u_div_yhi (.clk, .en, .num(opy_r.hi_mag), .den(opy_r.v_mag),
    .tag_in(opy_r.hi_neg), .quo(q_yhi), .rem_nz(nz_yhi), .tag_out(ng_yhi));

  // Sideband and valid bits run alongside the divider stages.
  pair_sb_t sb_r  [QW];
  logic     vld_r [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= '{x: opx_r.sb, y: opy_r.sb, ax_lt: ax_lt_r, ay_lt: ay_lt_r};
      for (int k = 1; k < QW; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= a_vld_r;
      for (int k = 1; k < QW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Saturation stage: quotients become entry and exit times per axis.
  logic signed [15:0] xin_r, xout_r, yin_r, yout_r;
  logic               xok_r, yok_r, fax_r, fay_r, f_vld_r;
  logic signed [15:0] t_xlo, t_xhi, t_ylo, t_yhi;
  pair_sb_t           sbe;

  always_comb begin
    sbe   = sb_r[QW-1];
    t_xlo = quo_sat(q_xlo, nz_xlo, ng_xlo);
    t_xhi = quo_sat(q_xhi, nz_xhi, ng_xhi);
    t_ylo = quo_sat(q_ylo, nz_ylo, ng_ylo);
    t_yhi = quo_sat(q_yhi, nz_yhi, ng_yhi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sbe.x.vzero) begin
        xin_r <= '0; xout_r <= T_ONE; xok_r <= sbe.x.still_ok;
      end else begin
        xin_r  <= sbe.x.vneg ? t_xhi : t_xlo;
        xout_r <= sbe.x.vneg ? t_xlo : t_xhi;
        xok_r  <= 1'b1;
      end
      if (sbe.y.vzero) begin
        yin_r <= '0; yout_r <= T_ONE; yok_r <= sbe.y.still_ok;
      end else begin
        yin_r  <= sbe.y.vneg ? t_yhi : t_ylo;
        yout_r <= sbe.y.vneg ? t_ylo : t_yhi;
        yok_r  <= 1'b1;
      end
      fax_r <= sbe.ax_lt;
      fay_r <= sbe.ay_lt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= vld_r[QW-1];
  end

  // Hit decision and face choice into the output register.
  logic               hit_nxt, hit_r, out_vld_r;
  logic signed [15:0] time_nxt, time_r;
  face_t              face_nxt, face_r;

  always_comb begin
    hit_nxt  = xok_r && yok_r && (xin_r <= T_ONE) && (xout_r >= 0) && (yin_r <= T_ONE) &&
               (yout_r >= 0) && (xin_r <= yout_r) && (yin_r <= xout_r);
    time_nxt = '0;
    face_nxt = FACE_0;
    if (hit_nxt) begin
      if (xin_r > yin_r) begin
        time_nxt = xin_r;
        face_nxt = fax_r ? FACE_PI : FACE_0;
      end else begin
        time_nxt = yin_r;
        face_nxt = fay_r ? FACE_3PI2 : FACE_PI2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      time_r <= time_nxt;
      face_r <= face_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= f_vld_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b00000, face_r, time_r, hit_r};

  `SWB_ASSERT_IMPL(a_nohit_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[18:1] == '0, "no-hit word carries nonzero fields")
  `SWB_ASSERT_IMPL(a_hit_time_rng, clk, rst_n, out_tvalid && out_tdata[0], $signed(out_tdata[16:1]) <= T_ONE, "hit time beyond one step")
  `SWB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(time_r) && $stable(f_vld_r), "pipeline moved during stall")
  `SWB_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_tvalid, "output valid right after reset")

endmodule

// ===== sv/swb_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on swb_pkg for the quotient width.
module swb_div import swb_pkg::*; #(
  parameter int NW = 30,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          tag_in,
  output logic [QW-1:0] quo,
  output logic          rem_nz,
  output logic          tag_out
);

  logic [NW-1:0] r_r   [QW];
  logic [DW-1:0] v_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic          tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int I = QW - 1 - k;
    logic [NW-1:0]    r_in, r_nxt;
    logic [DW-1:0]    v_in;
    logic [QW-1:0]    q_in, q_nxt;
    logic             t_in;
    logic [NW+QW-1:0] sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign v_in = den;
      assign q_in = '0;
      assign t_in = tag_in;
    end else begin : g_rest
      assign r_in = r_r[k-1];
      assign v_in = v_r[k-1];
      assign q_in = q_r[k-1];
      assign t_in = tag_r[k-1];
    end

    always_comb begin
      sh    = {{(NW+QW-DW){1'b0}}, v_in} << I;
      ge    = ({{QW{1'b0}}, r_in} >= sh);
      r_nxt = ge ? (r_in - sh[NW-1:0]) : r_in;
      q_nxt = q_in;
      q_nxt[I] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= r_nxt;
        v_r[k]   <= v_in;
        q_r[k]   <= q_nxt;
        tag_r[k] <= t_in;
      end
    end
  end

  assign quo     = q_r[QW-1];
  assign rem_nz  = (r_r[QW-1] != '0);
  assign tag_out = tag_r[QW-1];

endmodule

// ===== tb/tb.sv =====
// Regression testbench for swept_box_collision: directed and random box pairs,
// each result checked against an in-bench predictor. Depends on swb_pkg and the RTL.
`timescale 1ns / 100ps

module tb import swb_pkg::*;;

  localparam int CB = 16;
  localparam int IN_W = 8 * ((12 * CB - 4 + 7) / 8);
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] a_cx, a_cy;
    logic [14:0]        a_w, a_h;
    logic signed [15:0] a_vx, a_vy;
    logic signed [15:0] b_cx, b_cy;
    logic [14:0]        b_w, b_h;
    logic signed [15:0] b_vx, b_vy;
  } pair_t;

  // Members run from the top bit down, so hit lands in bit 0 as on out_tdata.
  typedef struct packed {
    face_t              face;
    logic signed [15:0] hit_time;
    logic               hit;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  contact_t expected_contacts[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  swept_box_collision u_dut (.*);

  // Floored quotient clamped to the Q4.12 range.
  function automatic longint floor_sat(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Entry and exit time of one axis; returns 0 when a still axis never overlaps.
  function automatic bit axis_window(longint ac, longint bc, longint sz, longint v,
                                     output longint t_in, output longint t_out);
    longint d, t1, t2;
    d = 2 * (bc - ac);
    t_in = 0;
    t_out = 0;
    if (v == 0) begin
      if (d > -sz && d < sz) begin
        t_out = 4096;
        return 1'b1;
      end
      return 1'b0;
    end
    t1 = floor_sat((d - sz) * 2048, v);
    t2 = floor_sat((d + sz) * 2048, v);
    t_in = (v < 0) ? t2 : t1;
    t_out = (v < 0) ? t1 : t2;
    return 1'b1;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint xi, xo, yi, yo;
    bit xv, yv;
    xv = axis_window(p.a_cx, p.b_cx, longint'(p.a_w) + longint'(p.b_w),
                     longint'(p.a_vx) - longint'(p.b_vx), xi, xo);
    yv = axis_window(p.a_cy, p.b_cy, longint'(p.a_h) + longint'(p.b_h),
                     longint'(p.a_vy) - longint'(p.b_vy), yi, yo);
    c = '{hit: 1'b0, hit_time: '0, face: FACE_0};
    if (xv && yv && xi <= 4096 && xo >= 0 && yi <= 4096 && yo >= 0 &&
        xi <= yo && yi <= xo) begin
      c.hit = 1'b1;
      if (xi > yi) begin
        c.hit_time = 16'(xi);
        c.face = (p.a_cx < p.b_cx) ? FACE_PI : FACE_0;
      end else begin
        c.hit_time = 16'(yi);
        c.face = (p.a_cy < p.b_cy) ? FACE_3PI2 : FACE_PI2;
      end
    end
    return c;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(pair_t p);
    return IN_W'({p.b_vy, p.b_vx, p.b_h, p.b_w, p.b_cy, p.b_cx,
                  p.a_vy, p.a_vx, p.a_h, p.a_w, p.a_cy, p.a_cx});
  endfunction

  // Sends one word, with bursts separated by random gaps.
  task automatic send_pair(pair_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= pack_pair(p);
    expected_contacts.push_back(predict_contact(p));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Receiver stall pattern: long ready runs mixed with choppy stretches.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((cycles / 200) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    contact_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = contact_t'(out_tdata[18:0]);
      if (expected_contacts.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        want = expected_contacts.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, got.hit);
          errors++;
        end
        if (got.hit_time !== want.hit_time) begin
          $error("hit_time: expected %0d actual %0d", want.hit_time, got.hit_time);
          errors++;
        end
        if (got.face !== want.face) begin
          $error("face_dir: expected %0d actual %0d", want.face, got.face);
          errors++;
        end
      end
    end
  end

  function automatic pair_t random_pair();
    pair_t p;
    p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return p;
  endfunction

  // Pairs placed close together with modest speeds so many of them meet.
  function automatic pair_t near_pair();
    pair_t p;
    p.a_cx = 16'($signed($urandom_range(0, 4000)) - 2000);
    p.a_cy = 16'($signed($urandom_range(0, 4000)) - 2000);
    p.b_cx = p.a_cx + 16'($signed($urandom_range(0, 1600)) - 800);
    p.b_cy = p.a_cy + 16'($signed($urandom_range(0, 1600)) - 800);
    p.a_w = 15'($urandom_range(0, 600));
    p.a_h = 15'($urandom_range(0, 600));
    p.b_w = 15'($urandom_range(0, 600));
    p.b_h = 15'($urandom_range(0, 600));
    p.a_vx = ($urandom_range(0, 4) == 0) ? '0 : 16'($signed($urandom_range(0, 1200)) - 600);
    p.a_vy = ($urandom_range(0, 4) == 0) ? '0 : 16'($signed($urandom_range(0, 1200)) - 600);
    p.b_vx = ($urandom_range(0, 3) == 0) ? p.a_vx : 16'($signed($urandom_range(0, 400)) - 200);
    p.b_vy = ($urandom_range(0, 3) == 0) ? p.a_vy : 16'($signed($urandom_range(0, 400)) - 200);
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    // Head-on along x: entry time inside the step, face toward B.
    p = '{a_cx: 0, a_cy: 0, a_w: 32, a_h: 32, a_vx: 160, a_vy: 0,
          b_cx: 100, b_cy: 0, b_w: 32, b_h: 32, b_vx: 0, b_vy: 0};
    send_pair(p);
    p.a_vx = -160; p.b_cx = -100; send_pair(p);
    // Along y both directions.
    p = '{a_cx: 0, a_cy: 0, a_w: 32, a_h: 32, a_vx: 0, a_vy: 160,
          b_cx: 0, b_cy: 100, b_w: 32, b_h: 32, b_vx: 0, b_vy: 0};
    send_pair(p);
    p.a_vy = -160; p.b_cy = -100; send_pair(p);
    // Already overlapping and moving: negative entry time.
    p = '{a_cx: 0, a_cy: 0, a_w: 64, a_h: 64, a_vx: 3, a_vy: 7,
          b_cx: 5, b_cy: 2, b_w: 64, b_h: 64, b_vx: 0, b_vy: 0};
    send_pair(p);
    // Still and overlapping, still and touching (no hit), still and apart.
    p.a_vx = 0; p.a_vy = 0; send_pair(p);
    p.b_cx = 64; send_pair(p);
    p.b_cx = 1000; send_pair(p);
    // Misses: too slow to arrive, then windows that do not overlap; odd quotients exercise floor rounding.
    p = '{a_cx: 0, a_cy: 0, a_w: 3, a_h: 3, a_vx: 7, a_vy: -3,
          b_cx: 300, b_cy: -5, b_w: 5, b_h: 1, b_vx: -1, b_vy: 0};
    send_pair(p);
    p.a_vx = 900; send_pair(p);
    // Saturation: tiny velocity, huge distance; then extreme velocities.
    p = '{a_cx: -32768, a_cy: -32768, a_w: 15'h7fff, a_h: 15'h7fff, a_vx: 1, a_vy: -1,
          b_cx: 32767, b_cy: 32767, b_w: 15'h7fff, b_h: 15'h7fff, b_vx: 0, b_vy: 0};
    send_pair(p);
    p.a_vx = -32768; p.b_vx = 32767; p.a_vy = 32767; p.b_vy = -32768; send_pair(p);
    p = '{a_cx: 32767, a_cy: 32767, a_w: 0, a_h: 0, a_vx: 32767, a_vy: -32768,
          b_cx: -32768, b_cy: -32768, b_w: 0, b_h: 0, b_vx: -32768, b_vy: 32767};
    send_pair(p);
    p = '{a_cx: 0, a_cy: 0, a_w: 0, a_h: 0, a_vx: 0, a_vy: 0,
          b_cx: 0, b_cy: 0, b_w: 0, b_h: 0, b_vx: 0, b_vy: 0};
    send_pair(p);
    p = '{a_cx: -1, a_cy: -1, a_w: 15'h7fff, a_h: 15'h7fff, a_vx: -1, a_vy: -1,
          b_cx: -1, b_cy: -1, b_w: 15'h7fff, b_h: 15'h7fff, b_vx: -1, b_vy: -1};
    send_pair(p);
    go_idle();
  endtask

  task automatic test_random();
    repeat (600) send_pair(($urandom_range(0, 3) == 0) ? random_pair() : near_pair());
    go_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("swept_box_collision regression: pass");
    else $display("swept_box_collision regression: fail");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("swept_box_collision regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/swb_pkg.sv
sv/swb_div.sv
sv/swept_box_collision.sv
tb/tb.sv
